// ===== rtl/cff_pkg.sv =====
// ----------------------------------------------------------------------------
// cff_pkg: shared types and constants for the command freshness failover
// Select codes, register indexes, reset values and fixed field widths.
// ----------------------------------------------------------------------------
package cff_pkg;

	// Width of the configuration registers and of the config write data.
	localparam int unsigned CFG_DATA_W  = 16;
	// Width of the config register index.
	localparam int unsigned CFG_INDEX_W = 2;
	// Width of the reported worst-latency fields.
	localparam int unsigned WORST_W     = 32;

	// Reset values of the configuration registers.
	localparam logic [CFG_DATA_W-1:0] AGE_LIMIT_RST    = 16'd50;
	localparam logic [CFG_DATA_W-1:0] WORST_PERIOD_RST = 16'd1000;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_AGE_LIMIT    = 2'd0,
		REG_WORST_PERIOD = 2'd1
	} cfg_reg_t;

	// Command source select codes.
	typedef enum logic [1:0] {
		SEL_PRIMARY = 2'd0,
		SEL_BACKUP  = 2'd1,
		SEL_COAST   = 2'd2
	} select_t;

endpackage

// ===== rtl/cff_source_check.sv =====
// ----------------------------------------------------------------------------
// cff_source_check: freshness check for one command source
// Flags a timing failure from the seen flags and stamp distances, and gives
// the source latency used by the worst-latency tracker.
// ----------------------------------------------------------------------------
module cff_source_check
	import cff_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic [TIME_WIDTH-1:0] now_ms,
	input  logic                  speed_seen,
	input  logic [TIME_WIDTH-1:0] speed_stamp,
	input  logic                  torque_seen,
	input  logic [TIME_WIDTH-1:0] torque_stamp,
	input  logic [CFG_DATA_W-1:0] age_limit,
	output logic                  failed,
	output logic [TIME_WIDTH-1:0] latency
);

	logic [TIME_WIDTH-1:0] sp_age;
	logic [TIME_WIDTH-1:0] sp_lead;
	logic [TIME_WIDTH-1:0] tq_age;
	logic [TIME_WIDTH-1:0] tq_lead;
	logic [TIME_WIDTH-1:0] skew_a;
	logic [TIME_WIDTH-1:0] skew_b;
	logic [TIME_WIDTH-1:0] sp_dist;
	logic [TIME_WIDTH-1:0] tq_dist;
	logic [TIME_WIDTH-1:0] skew_dist;
	logic [TIME_WIDTH-1:0] limit;
	logic [TIME_WIDTH-1:0] half_limit;

	// Wrapped differences in both directions.
	assign sp_age  = now_ms - speed_stamp;
	assign sp_lead = speed_stamp - now_ms;
	assign tq_age  = now_ms - torque_stamp;
	assign tq_lead = torque_stamp - now_ms;
	assign skew_a  = speed_stamp - torque_stamp;
	assign skew_b  = torque_stamp - speed_stamp;

	// Distance across wrap is the smaller of the two differences.
	assign sp_dist   = (sp_age < sp_lead) ? sp_age : sp_lead;
	assign tq_dist   = (tq_age < tq_lead) ? tq_age : tq_lead;
	assign skew_dist = (skew_a < skew_b) ? skew_a : skew_b;

	// Limits widened to the time width.
	assign limit      = TIME_WIDTH'(age_limit);
	assign half_limit = TIME_WIDTH'(age_limit >> 1);

	// A source fails on a missing message, an old message or skewed stamps.
	assign failed = !speed_seen || !torque_seen || (sp_dist > limit) ||
		(tq_dist > limit) || (skew_dist > half_limit);

	// Tracker latency is the larger plain age, seen flags ignored.
	assign latency = (sp_age > tq_age) ? sp_age : tq_age;

endmodule

// ===== rtl/cff_state.sv =====
// ----------------------------------------------------------------------------
// cff_state: run latch, source selection and worst-latency trackers
// Holds the block state and advances it by one tick whenever a beat moves
// into the result register.
// ----------------------------------------------------------------------------
module cff_state
	import cff_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [TIME_WIDTH-1:0] now_ms,
	input  logic                  reset_pressed,
	input  logic                  pri_fail,
	input  logic                  bak_fail,
	input  logic [TIME_WIDTH-1:0] pri_latency,
	input  logic [TIME_WIDTH-1:0] bak_latency,
	input  logic [CFG_DATA_W-1:0] worst_period,
	output select_t               sel_next,
	output logic                  running_next,
	output logic [WORST_W-1:0]    pri_worst_next,
	output logic [WORST_W-1:0]    bak_worst_next
);

	logic                  run_q;
	logic [TIME_WIDTH-1:0] period_q;
	logic [TIME_WIDTH-1:0] pri_worst_q;
	logic [TIME_WIDTH-1:0] bak_worst_q;

	logic                  latch_set;
	logic [TIME_WIDTH-1:0] period_base;
	logic [TIME_WIDTH-1:0] period_age;
	logic                  period_over;
	logic [TIME_WIDTH-1:0] period_d;
	logic [TIME_WIDTH-1:0] pri_base;
	logic [TIME_WIDTH-1:0] bak_base;
	logic [TIME_WIDTH-1:0] pri_worst_d;
	logic [TIME_WIDTH-1:0] bak_worst_d;
	logic [TIME_WIDTH+WORST_W-1:0] pri_ext;
	logic [TIME_WIDTH+WORST_W-1:0] bak_ext;

	// The button sets the latch; the first fresh source wins, else coast.
	assign latch_set = run_q || reset_pressed;

	always_comb begin
		if (latch_set && !pri_fail) begin
			sel_next     = SEL_PRIMARY;
			running_next = 1'b1;
		end else if (latch_set && !bak_fail) begin
			sel_next     = SEL_BACKUP;
			running_next = 1'b1;
		end else begin
			sel_next     = SEL_COAST;
			running_next = 1'b0;
		end
	end

	// A zero period start means not started yet, so it takes the current time.
	assign period_base = (period_q == '0) ? now_ms : period_q;
	assign period_age  = now_ms - period_base;
	assign period_over = period_age > TIME_WIDTH'(worst_period);
	assign period_d    = period_over ? now_ms : period_base;

	// Trackers clear at a period boundary before this tick is folded in.
	assign pri_base    = period_over ? '0 : pri_worst_q;
	assign bak_base    = period_over ? '0 : bak_worst_q;
	assign pri_worst_d = (pri_latency > pri_base) ? pri_latency : pri_base;
	assign bak_worst_d = (bak_latency > bak_base) ? bak_latency : bak_base;

	// Reported trackers are the low bits, zero extended for narrow times.
	assign pri_ext        = {{WORST_W{1'b0}}, pri_worst_d};
	assign bak_ext        = {{WORST_W{1'b0}}, bak_worst_d};
	assign pri_worst_next = pri_ext[WORST_W-1:0];
	assign bak_worst_next = bak_ext[WORST_W-1:0];

	// State update, one tick per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			period_q    <= '0;
			pri_worst_q <= '0;
			bak_worst_q <= '0;
		end else if (step) begin
			run_q       <= running_next;
			period_q    <= period_d;
			pri_worst_q <= pri_worst_d;
			bak_worst_q <= bak_worst_d;
		end
	end

endmodule

// ===== rtl/command_freshness_failover.sv =====
// ----------------------------------------------------------------------------
// command_freshness_failover: command source choice by message freshness
// Input register, per-source freshness checks, state update and result
// register.
// ----------------------------------------------------------------------------
// Each tick beat gives the time and the message stamps of a primary and a
// backup command source; each yields one result beat with the select code
// (primary, backup or coast), the run latch, both failure flags and the
// worst latency of each source in the current period. A tick is held in the
// input register and moves into the result register once that register is
// free or drains, so a result is offered only after its tick has passed both
// registers. One tick is taken every cycle as long as results are taken, and
// a single pass of subtract-compare logic lies between the two registers.
// The result register lets a new tick be taken while the previous result
// still waits.
// Configuration writes should be made only while no beat is in flight.
// ----------------------------------------------------------------------------
module command_freshness_failover
	import cff_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	// Tick channel.
	input  logic                   tick_valid,
	output logic                   tick_stall,
	input  logic [TIME_WIDTH-1:0]  now_ms,
	input  logic                   reset_pressed,
	input  logic                   pri_speed_seen,
	input  logic [TIME_WIDTH-1:0]  pri_speed_stamp,
	input  logic                   pri_torque_seen,
	input  logic [TIME_WIDTH-1:0]  pri_torque_stamp,
	input  logic                   bak_speed_seen,
	input  logic [TIME_WIDTH-1:0]  bak_speed_stamp,
	input  logic                   bak_torque_seen,
	input  logic [TIME_WIDTH-1:0]  bak_torque_stamp,

	// Result channel.
	output logic                   sel_valid,
	input  logic                   sel_stall,
	output logic [1:0]             select,
	output logic                   running,
	output logic                   pri_failed,
	output logic                   bak_failed,
	output logic [WORST_W-1:0]     pri_worst,
	output logic [WORST_W-1:0]     bak_worst
);

	logic [CFG_DATA_W-1:0] age_limit_q;
	logic [CFG_DATA_W-1:0] worst_period_q;

	logic                  valid_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  reset_pressed_s1;
	logic                  pri_speed_seen_s1;
	logic [TIME_WIDTH-1:0] pri_speed_stamp_s1;
	logic                  pri_torque_seen_s1;
	logic [TIME_WIDTH-1:0] pri_torque_stamp_s1;
	logic                  bak_speed_seen_s1;
	logic [TIME_WIDTH-1:0] bak_speed_stamp_s1;
	logic                  bak_torque_seen_s1;
	logic [TIME_WIDTH-1:0] bak_torque_stamp_s1;

	logic                  advance;
	logic                  pri_fail;
	logic                  bak_fail;
	logic [TIME_WIDTH-1:0] pri_latency;
	logic [TIME_WIDTH-1:0] bak_latency;
	select_t               sel_next;
	logic                  running_next;
	logic [WORST_W-1:0]    pri_worst_next;
	logic [WORST_W-1:0]    bak_worst_next;

	logic                  valid_s2;
	select_t               select_s2;
	logic                  running_s2;
	logic                  pri_failed_s2;
	logic                  bak_failed_s2;
	logic [WORST_W-1:0]    pri_worst_s2;
	logic [WORST_W-1:0]    bak_worst_s2;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q    <= AGE_LIMIT_RST;
			worst_period_q <= WORST_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AGE_LIMIT:    age_limit_q    <= cfg_data;
				REG_WORST_PERIOD: worst_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A beat moves to the result register when that register is free or drains.
	assign advance    = valid_s1 && (!valid_s2 || !sel_stall);
	assign tick_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			now_s1              <= now_ms;
			reset_pressed_s1    <= reset_pressed;
			pri_speed_seen_s1   <= pri_speed_seen;
			pri_speed_stamp_s1  <= pri_speed_stamp;
			pri_torque_seen_s1  <= pri_torque_seen;
			pri_torque_stamp_s1 <= pri_torque_stamp;
			bak_speed_seen_s1   <= bak_speed_seen;
			bak_speed_stamp_s1  <= bak_speed_stamp;
			bak_torque_seen_s1  <= bak_torque_seen;
			bak_torque_stamp_s1 <= bak_torque_stamp;
		end
	end

	// Freshness checks for both sources.
	cff_source_check #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_pri_check (
		.now_ms      (now_s1),
		.speed_seen  (pri_speed_seen_s1),
		.speed_stamp (pri_speed_stamp_s1),
		.torque_seen (pri_torque_seen_s1),
		.torque_stamp(pri_torque_stamp_s1),
		.age_limit   (age_limit_q),
		.failed      (pri_fail),
		.latency     (pri_latency)
	);

	cff_source_check #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_bak_check (
		.now_ms      (now_s1),
		.speed_seen  (bak_speed_seen_s1),
		.speed_stamp (bak_speed_stamp_s1),
		.torque_seen (bak_torque_seen_s1),
		.torque_stamp(bak_torque_stamp_s1),
		.age_limit   (age_limit_q),
		.failed      (bak_fail),
		.latency     (bak_latency)
	);

	// Selection, run latch and trackers.
	cff_state #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.now_ms        (now_s1),
		.reset_pressed (reset_pressed_s1),
		.pri_fail      (pri_fail),
		.bak_fail      (bak_fail),
		.pri_latency   (pri_latency),
		.bak_latency   (bak_latency),
		.worst_period  (worst_period_q),
		.sel_next      (sel_next),
		.running_next  (running_next),
		.pri_worst_next(pri_worst_next),
		.bak_worst_next(bak_worst_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!sel_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			select_s2     <= sel_next;
			running_s2    <= running_next;
			pri_failed_s2 <= pri_fail;
			bak_failed_s2 <= bak_fail;
			pri_worst_s2  <= pri_worst_next;
			bak_worst_s2  <= bak_worst_next;
		end
	end

	assign sel_valid  = valid_s2;
	assign select     = select_s2;
	assign running    = running_s2;
	assign pri_failed = pri_failed_s2;
	assign bak_failed = bak_failed_s2;
	assign pri_worst  = pri_worst_s2;
	assign bak_worst  = bak_worst_s2;

	// The latch is set exactly when a command source is selected.
	a_running_matches_select: assert property (@(posedge clk) disable iff (!arst_n)
		sel_valid |-> (running == (select != SEL_COAST)))
		else $error("run latch disagrees with select code");

	// The primary is never selected while it fails.
	a_primary_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		sel_valid && (select == SEL_PRIMARY) |-> !pri_failed)
		else $error("failed primary selected");

	// The backup is selected only when the primary fails and the backup is fresh.
	a_backup_order: assert property (@(posedge clk) disable iff (!arst_n)
		sel_valid && (select == SEL_BACKUP) |-> pri_failed && !bak_failed)
		else $error("backup selected out of order");

	// A beat that moves on leaves a valid result behind it.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> sel_valid)
		else $error("result register lost a beat");

endmodule
